// ===== hdl/bat_pkg.sv =====
`timescale 1ns / 1ps

package bat_pkg;

  // Widths sized for the largest supported table of 64 slots.
  localparam int unsigned BAT_IDX_W  = 6;
  localparam int unsigned BAT_CNT_W  = 7;
  localparam int unsigned BAT_ADDR_W = 32;

  typedef enum logic [1:0] {
    CMD_SET       = 2'd0,
    CMD_CLEAR     = 2'd1,
    CMD_CLEAR_ALL = 2'd2,
    CMD_MATCH     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD      = 3'd1,
    ST_DUP      = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTSET   = 3'd4,
    ST_NOMATCH  = 3'd5
  } status_e;

  // Token that walks the slot chain, one cell per cycle.
  typedef struct packed {
    logic                  valid;
    cmd_e                  cmd;
    logic [BAT_ADDR_W-1:0] key;
    logic                  bad;
    logic                  dup;
    logic                  found;
    logic [BAT_IDX_W-1:0]  idx;
    logic                  free_found;
    logic [BAT_IDX_W-1:0]  free_idx;
    logic [BAT_CNT_W-1:0]  count;
  } tok_t;

  // Slot write issued at the end of a set pass.
  typedef struct packed {
    logic                  en;
    logic [BAT_IDX_W-1:0]  idx;
    logic [BAT_ADDR_W-1:0] data;
  } wr_t;

endpackage

// ===== hdl/bat_if.sv =====
`timescale 1ns / 1ps

interface bat_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] address;

  modport source (output valid, output command, output address, input ready);
  modport sink (input valid, input command, input address, output ready);
endinterface

interface bat_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] slot;
  logic [3:0] occupied;

  modport source (output valid, output status, output slot, output occupied, input ready);
  modport sink (input valid, input status, input slot, input occupied, output ready);
endinterface

// ===== hdl/bat_cell.sv =====
`timescale 1ns / 1ps

module bat_cell
  import bat_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  tok_t tok_i,
  input  wr_t  wr_i,
  output tok_t tok_o
);

  localparam logic [BAT_IDX_W-1:0] MyIdx = BAT_IDX_W'(IDX);

  logic [BAT_ADDR_W-1:0] slot_q, slot_d;
  tok_t                  tok_q, tok_d;
  logic                  hit;

  // A zero key never hits, since zero marks an empty slot.
  assign hit = (slot_q == tok_i.key) && (tok_i.key != '0);

  // Update the passing token and this cell's slot.
  always_comb begin
    tok_d  = tok_i;
    slot_d = slot_q;
    if (tok_i.valid) begin
      case (tok_i.cmd)
        CMD_SET: begin
          if (hit) begin
            tok_d.dup = 1'b1;
          end
          if (slot_q == '0) begin
            tok_d.free_found = 1'b1;
            tok_d.free_idx   = MyIdx;
          end
        end
        CMD_CLEAR: begin
          if (hit && !tok_i.found) begin
            tok_d.found = 1'b1;
            tok_d.idx   = MyIdx;
            slot_d      = '0;
          end
        end
        CMD_CLEAR_ALL: begin
          slot_d = '0;
        end
        CMD_MATCH: begin
          if (hit && !tok_i.found) begin
            tok_d.found = 1'b1;
            tok_d.idx   = MyIdx;
          end
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
      tok_d.count = tok_i.count + BAT_CNT_W'(slot_d != '0);
    end
    // The end-of-pass write never coincides with a token in the chain.
    if (wr_i.en && (wr_i.idx == MyIdx)) begin
      slot_d = wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      tok_q  <= '0;
    end else begin
      slot_q <= slot_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== hdl/breakpoint_address_table_unit.sv =====
`timescale 1ns / 1ps
// One transaction at a time: a new one is taken only once the previous result has been
// loaded into the output register. The command token walks the chain of slot cells one
// cell per cycle, and a set writes its slot at the end.
// A finished result may wait in the output register while the next command walks.
// Reset (asynchronous, active low) empties every slot and clears all control state.

module breakpoint_address_table_unit
  import bat_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bat_in_if.sink           in_i,
  bat_out_if.source        out_o
);

  tok_t tok [NUM_SLOTS+1];
  tok_t tok0_q, tok0_d;
  tok_t tok_end;
  wr_t  wr;

  logic busy_q, busy_d;
  logic accept;

  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q, out_status_d;
  logic [BAT_IDX_W-1:0] out_slot_q, out_slot_d;
  logic [BAT_CNT_W-1:0] out_cnt_q, out_cnt_d;

  logic                 pend_valid_q, pend_valid_d;
  status_e              pend_status_q, pend_status_d;
  logic [BAT_IDX_W-1:0] pend_slot_q, pend_slot_d;
  logic [BAT_CNT_W-1:0] pend_cnt_q, pend_cnt_d;

  status_e              res_status;
  logic [BAT_IDX_W-1:0] res_slot;
  logic [BAT_CNT_W-1:0] res_cnt;

  logic out_free, load_chain, load_pend, pend_to_out;
  logic [BAT_IDX_W+2:0] slot_ext;
  logic [BAT_CNT_W+3:0] cnt_ext;

  assign in_i.ready = !busy_q;
  assign accept     = in_i.valid && !busy_q;

  // Build the token that enters the first cell.
  always_comb begin
    tok0_d       = '0;
    tok0_d.valid = accept;
    tok0_d.cmd   = cmd_e'(in_i.command);
    tok0_d.key   = in_i.address;
    case (cmd_e'(in_i.command))
      CMD_SET: begin
        tok0_d.bad = (in_i.address == '0) || in_i.address[0];
        if (tok0_d.bad) begin
          tok0_d.key = '0;
        end
      end
      CMD_MATCH: begin
        tok0_d.key = in_i.address - BAT_ADDR_W'(2);
      end
      default: begin
        tok0_d.key = in_i.address;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok0_q <= '0;
    end else begin
      tok0_q <= tok0_d;
    end
  end

  assign tok[0] = tok0_q;

  // Chain of slot cells.
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    bat_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok[g]),
      .wr_i   (wr),
      .tok_o  (tok[g+1])
    );
  end

  assign tok_end = tok[NUM_SLOTS];

  // Resolve the command once the token leaves the last cell.
  always_comb begin
    res_status = ST_OK;
    res_slot   = '0;
    res_cnt    = tok_end.count;
    wr         = '0;
    case (tok_end.cmd)
      CMD_SET: begin
        if (tok_end.bad) begin
          res_status = ST_BAD;
        end else if (tok_end.dup) begin
          res_status = ST_DUP;
        end else if (!tok_end.free_found) begin
          res_status = ST_FULL;
        end else begin
          res_slot = tok_end.free_idx;
          res_cnt  = tok_end.count + BAT_CNT_W'(1);
          wr.en    = tok_end.valid;
          wr.idx   = tok_end.free_idx;
          wr.data  = tok_end.key;
        end
      end
      CMD_CLEAR: begin
        if (tok_end.found) begin
          res_slot = tok_end.idx;
        end else begin
          res_status = ST_NOTSET;
        end
      end
      CMD_CLEAR_ALL: begin
        res_status = ST_OK;
      end
      CMD_MATCH: begin
        if (tok_end.found) begin
          res_slot = tok_end.idx;
        end else begin
          res_status = ST_NOMATCH;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // Output register with a holding stage behind it.
  assign out_free    = !out_valid_q || out_o.ready;
  assign pend_to_out = pend_valid_q && out_free;
  assign load_chain  = tok_end.valid && out_free;
  assign load_pend   = tok_end.valid && !out_free;

  always_comb begin
    out_valid_d   = out_valid_q;
    out_status_d  = out_status_q;
    out_slot_d    = out_slot_q;
    out_cnt_d     = out_cnt_q;
    pend_valid_d  = pend_valid_q;
    pend_status_d = pend_status_q;
    pend_slot_d   = pend_slot_q;
    pend_cnt_d    = pend_cnt_q;
    busy_d        = busy_q;
    if (out_free) begin
      out_valid_d = 1'b0;
    end
    if (pend_to_out) begin
      out_valid_d  = 1'b1;
      out_status_d = pend_status_q;
      out_slot_d   = pend_slot_q;
      out_cnt_d    = pend_cnt_q;
      pend_valid_d = 1'b0;
      busy_d       = 1'b0;
    end else if (load_chain) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status;
      out_slot_d   = res_slot;
      out_cnt_d    = res_cnt;
      busy_d       = 1'b0;
    end else if (load_pend) begin
      pend_valid_d  = 1'b1;
      pend_status_d = res_status;
      pend_slot_d   = res_slot;
      pend_cnt_d    = res_cnt;
    end
    if (accept) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      busy_q       <= busy_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q  <= out_status_d;
    out_slot_q    <= out_slot_d;
    out_cnt_q     <= out_cnt_d;
    pend_status_q <= pend_status_d;
    pend_slot_q   <= pend_slot_d;
    pend_cnt_q    <= pend_cnt_d;
  end

  // Only the low bits of the slot number and the count leave the block.
  assign slot_ext = {3'b000, out_slot_q};
  assign cnt_ext  = {4'b0000, out_cnt_q};

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = out_status_q;
  assign out_o.slot     = slot_ext[2:0];
  assign out_o.occupied = cnt_ext[3:0];

endmodule
